// ----- hdl/tsb_pkg.sv -----
// ----------------------------------------------------------------------------
// tsb_pkg: shared constants, types and helpers of the tile seam blend unit
// Image and tile geometry, blend select codes, the per-word control record
// passed from the sequencer to the blend stage, and the channel average.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int IMG_SIZE   = 1024;
  localparam int TILE_SIZE  = 16;
  localparam int TILE_COUNT = IMG_SIZE / TILE_SIZE;

  localparam int RGB_W     = 24;
  localparam int CH_W      = 8;
  localparam int OUT_POS_W = 10;
  localparam int POS_W     = $clog2(IMG_SIZE);
  localparam int ROW_W     = POS_W + 1;
  localparam int PH_W      = $clog2(TILE_SIZE);
  localparam int TIDX_W    = $clog2(TILE_COUNT + 1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int SEL_W = 3;
  localparam logic [SEL_W-1:0] SEL_SELF  = 3'd0;
  localparam logic [SEL_W-1:0] SEL_BELOW = 3'd1;
  localparam logic [SEL_W-1:0] SEL_ABOVE = 3'd2;
  localparam logic [SEL_W-1:0] SEL_RIGHT = 3'd3;
  localparam logic [SEL_W-1:0] SEL_LEFT  = 3'd4;

  typedef logic [RGB_W-1:0] rgb_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic             write;      // pixel word that updates the line buffers
    logic             emit;       // word produces an output word
    logic [SEL_W-1:0] sel;
    pos_t             row;
    pos_t             col;
    logic             frame_end;
    rgb_t             pix;
  } item_t;

  // Per-channel floor average of two packed colors.
  function automatic rgb_t avg_rgb(input rgb_t a, input rgb_t b);
    rgb_t          res;
    logic [CH_W:0] sum;
    res = '0;
    for (int ch = 0; ch < RGB_W / CH_W; ch++) begin
      sum = {1'b0, a[ch*CH_W +: CH_W]} + {1'b0, b[ch*CH_W +: CH_W]};
      res[ch*CH_W +: CH_W] = sum[CH_W:1];
    end
    return res;
  endfunction

endpackage

// ----- hdl/tsb_line_store.sv -----
// ----------------------------------------------------------------------------
// tsb_line_store: the two line buffers
// The latest row has two read ports (own column and the column to its right)
// and is rewritten at the read edge; the older row is read at the own column
// and written back from the blend stage. Read data is registered.
// ----------------------------------------------------------------------------
module tsb_line_store (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [tsb_pkg::POS_W-1:0] a_addr,
  input  logic [tsb_pkg::POS_W-1:0] b_addr,
  input  logic                      prev_we,
  input  logic [tsb_pkg::RGB_W-1:0] prev_wdata,
  input  logic                      older_we,
  input  logic [tsb_pkg::POS_W-1:0] older_waddr,
  input  logic [tsb_pkg::RGB_W-1:0] older_wdata,
  output logic [tsb_pkg::RGB_W-1:0] self_rgb,
  output logic [tsb_pkg::RGB_W-1:0] right_rgb,
  output logic [tsb_pkg::RGB_W-1:0] above_rgb
);
  import tsb_pkg::*;

  rgb_t prev_mem  [IMG_SIZE];
  rgb_t older_mem [IMG_SIZE];

  // A read and a write of the same entry at one edge return the old value.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      self_rgb  <= prev_mem[a_addr];
      right_rgb <= prev_mem[b_addr];
    end
    if (prev_we) begin
      prev_mem[a_addr] <= prev_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      above_rgb <= older_mem[a_addr];
    end
    if (older_we) begin
      older_mem[older_waddr] <= older_wdata;
    end
  end

endmodule

// ----- hdl/tsb_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsb_ctrl: position sequencer
// Tracks input column and row, tile phase and index of both axes, and the
// drain column. Classifies each accepted word and picks the blend source.
// ----------------------------------------------------------------------------
module tsb_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      op,
  input  logic [tsb_pkg::RGB_W-1:0] pixel_rgb,
  output tsb_pkg::item_t            item,
  output logic                      mem_we,
  output logic [tsb_pkg::POS_W-1:0] a_addr,
  output logic [tsb_pkg::POS_W-1:0] b_addr
);
  import tsb_pkg::*;

  pos_t              in_col, in_col_next;
  logic [ROW_W-1:0]  in_row, in_row_next;
  pos_t              flush_col, flush_col_next;
  logic [PH_W-1:0]   col_ph, col_ph_next;
  logic [TIDX_W-1:0] col_tile, col_tile_next;
  logic [PH_W-1:0]   row_ph, row_ph_next;
  logic [TIDX_W-1:0] row_tile, row_tile_next;
  // Phase and tile index of the row being emitted (one behind the input row).
  logic [PH_W-1:0]   out_ph, out_ph_next;
  logic [TIDX_W-1:0] out_tile, out_tile_next;

  logic             row_full, pix_go, flush_go, col_last, fcol_last;
  logic             row_inner, col_inner;
  logic [ROW_W-1:0] row_m1;
  logic [SEL_W-1:0] sel;

  assign row_full  = (in_row == ROW_W'(IMG_SIZE));
  assign pix_go    = (op == OP_PIXEL) && !row_full;
  assign flush_go  = (op == OP_FLUSH) && row_full;
  assign col_last  = (in_col == POS_W'(IMG_SIZE - 1));
  assign fcol_last = (flush_col == POS_W'(IMG_SIZE - 1));
  assign row_m1    = in_row - ROW_W'(1);

  assign row_inner = (out_tile >= TIDX_W'(1)) && (int'(out_tile) <= TILE_COUNT - 2);
  assign col_inner = (col_tile >= TIDX_W'(1)) && (int'(col_tile) <= TILE_COUNT - 2);

  // Top and bottom tile edges take priority over left and right ones.
  always_comb begin
    sel = SEL_SELF;
    if (row_inner && col_inner) begin
      if (out_ph == PH_W'(TILE_SIZE - 1)) begin
        sel = SEL_BELOW;
      end else if (out_ph == '0) begin
        sel = SEL_ABOVE;
      end else if (col_ph == PH_W'(TILE_SIZE - 1) && !col_last) begin
        sel = SEL_RIGHT;
      end else if (col_ph == '0 && in_col != '0) begin
        sel = SEL_LEFT;
      end
    end
  end

  always_comb begin
    item.write     = pix_go;
    item.emit      = flush_go || (pix_go && in_row != '0);
    item.sel       = flush_go ? SEL_SELF : sel;
    item.row       = flush_go ? POS_W'(IMG_SIZE - 1) : row_m1[POS_W-1:0];
    item.col       = flush_go ? flush_col : in_col;
    item.frame_end = flush_go && fcol_last;
    item.pix       = pixel_rgb;
  end

  assign mem_we = accept && pix_go;
  assign a_addr = (op == OP_FLUSH) ? flush_col : in_col;
  assign b_addr = in_col + POS_W'(1);

  always_comb begin
    in_col_next    = in_col;
    in_row_next    = in_row;
    flush_col_next = flush_col;
    col_ph_next    = col_ph;
    col_tile_next  = col_tile;
    row_ph_next    = row_ph;
    row_tile_next  = row_tile;
    out_ph_next    = out_ph;
    out_tile_next  = out_tile;
    if (accept && pix_go) begin
      if (col_last) begin
        in_col_next   = '0;
        col_ph_next   = '0;
        col_tile_next = '0;
        in_row_next   = in_row + ROW_W'(1);
        out_ph_next   = row_ph;
        out_tile_next = row_tile;
        if (row_ph == PH_W'(TILE_SIZE - 1)) begin
          row_ph_next   = '0;
          row_tile_next = row_tile + TIDX_W'(1);
        end else begin
          row_ph_next = row_ph + PH_W'(1);
        end
      end else begin
        in_col_next = in_col + POS_W'(1);
        if (col_ph == PH_W'(TILE_SIZE - 1)) begin
          col_ph_next   = '0;
          col_tile_next = col_tile + TIDX_W'(1);
        end else begin
          col_ph_next = col_ph + PH_W'(1);
        end
      end
    end
    if (accept && flush_go) begin
      if (fcol_last) begin
        flush_col_next = '0;
        in_row_next    = '0;
        in_col_next    = '0;
        row_ph_next    = '0;
        row_tile_next  = '0;
      end else begin
        flush_col_next = flush_col + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col    <= '0;
      in_row    <= '0;
      flush_col <= '0;
      col_ph    <= '0;
      col_tile  <= '0;
      row_ph    <= '0;
      row_tile  <= '0;
      out_ph    <= '0;
      out_tile  <= '0;
    end else begin
      in_col    <= in_col_next;
      in_row    <= in_row_next;
      flush_col <= flush_col_next;
      col_ph    <= col_ph_next;
      col_tile  <= col_tile_next;
      row_ph    <= row_ph_next;
      row_tile  <= row_tile_next;
      out_ph    <= out_ph_next;
      out_tile  <= out_tile_next;
    end
  end

endmodule

// ----- hdl/tsb_blend.sv -----
// ----------------------------------------------------------------------------
// tsb_blend: blend stage and output register
// Holds the word whose line-buffer reads are in flight, forms the blended
// color, writes the older row back, and presents the result word.
// ----------------------------------------------------------------------------
module tsb_blend (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  tsb_pkg::item_t                item,
  input  logic [tsb_pkg::RGB_W-1:0]     self_rgb,
  input  logic [tsb_pkg::RGB_W-1:0]     right_rgb,
  input  logic [tsb_pkg::RGB_W-1:0]     above_rgb,
  output logic                          stage_free,
  output logic                          older_we,
  output logic [tsb_pkg::POS_W-1:0]     older_waddr,
  output logic [tsb_pkg::RGB_W-1:0]     older_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsb_pkg::RGB_W-1:0]     out_rgb,
  output logic [tsb_pkg::OUT_POS_W-1:0] out_row,
  output logic [tsb_pkg::OUT_POS_W-1:0] out_col,
  output logic                          out_frame_end
);
  import tsb_pkg::*;

  logic  s1_valid;
  item_t s1_item;
  rgb_t  left_rgb;
  rgb_t  blend_rgb;
  logic  s1_adv, out_load;

  assign s1_adv     = s1_valid && (!out_valid || out_ready);
  assign stage_free = !s1_valid || s1_adv;
  assign out_load   = s1_adv && s1_item.emit;

  always_comb begin
    case (s1_item.sel)
      SEL_BELOW: blend_rgb = avg_rgb(self_rgb, s1_item.pix);
      SEL_ABOVE: blend_rgb = avg_rgb(self_rgb, above_rgb);
      SEL_RIGHT: blend_rgb = avg_rgb(self_rgb, right_rgb);
      SEL_LEFT:  blend_rgb = avg_rgb(self_rgb, left_rgb);
      default:   blend_rgb = self_rgb;
    endcase
  end

  assign older_we    = s1_adv && s1_item.write;
  assign older_waddr = s1_item.col;
  assign older_wdata = self_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
    // The original color of the previous column of this row is the left seam.
    if (older_we) begin
      left_rgb <= self_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rgb       <= blend_rgb;
      out_row       <= OUT_POS_W'(s1_item.row);
      out_col       <= OUT_POS_W'(s1_item.col);
      out_frame_end <= s1_item.frame_end;
    end
  end

endmodule

// ----- hdl/tile_seam_blend_unit.sv -----
// ----------------------------------------------------------------------------
// tile_seam_blend_unit: tile seam smoothing over a raster RGB image
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_ready  | op, pixel_rgb
//   output   | out_valid / out_ready| out_rgb, out_row, out_col, out_frame_end
//
// One word per cycle sustained while out_ready stays high. A word's line-buffer
// reads are registered at the edge that accepts it, and the blended result of
// an emitting word is registered when the blend stage advances, which a stalled
// output delays. Reset clears counters and valid flags only; the line buffers
// start unwritten. A stalled output holds the blend stage, and in_ready drops
// only when both the blend stage and output register are full.
// ----------------------------------------------------------------------------
module tile_seam_blend_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [tsb_pkg::RGB_W-1:0]     pixel_rgb,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsb_pkg::RGB_W-1:0]     out_rgb,
  output logic [tsb_pkg::OUT_POS_W-1:0] out_row,
  output logic [tsb_pkg::OUT_POS_W-1:0] out_col,
  output logic                          out_frame_end
);
  import tsb_pkg::*;

  logic  accept, stage_free, mem_we, older_we;
  item_t item;
  pos_t  a_addr, b_addr, older_waddr;
  rgb_t  self_rgb, right_rgb, above_rgb, older_wdata;

  assign in_ready = stage_free;
  assign accept   = in_valid && in_ready;

  tsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .pixel_rgb (pixel_rgb),
    .item      (item),
    .mem_we    (mem_we),
    .a_addr    (a_addr),
    .b_addr    (b_addr)
  );

  tsb_line_store u_store (
    .clk         (clk),
    .rd_en       (accept),
    .a_addr      (a_addr),
    .b_addr      (b_addr),
    .prev_we     (mem_we),
    .prev_wdata  (pixel_rgb),
    .older_we    (older_we),
    .older_waddr (older_waddr),
    .older_wdata (older_wdata),
    .self_rgb    (self_rgb),
    .right_rgb   (right_rgb),
    .above_rgb   (above_rgb)
  );

  tsb_blend u_blend (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .self_rgb      (self_rgb),
    .right_rgb     (right_rgb),
    .above_rgb     (above_rgb),
    .stage_free    (stage_free),
    .older_we      (older_we),
    .older_waddr   (older_waddr),
    .older_wdata   (older_wdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rgb       (out_rgb),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_frame_end (out_frame_end)
  );

endmodule
